### hw/rtl/maft_pkg.sv
package maft_pkg;

   // Table geometry.
   localparam int unsigned MAX_ENTRIES = 1024;
   localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
   localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned OCTETS      = ADDR_W / 8;

   // Item kinds.
   localparam logic [1:0] KIND_CHECK  = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_MISS = 2'd2;

   // Input word.
   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] source_address;
      logic [ADDR_W-1:0] filter_pattern;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic             reject;
      logic [1:0]       status;
      logic [CNT_W-1:0] entry_total;
   } rsp_word_type;

   // Each nonzero octet of a pattern is compared in full, a zero octet is a wildcard.
   function automatic logic [ADDR_W-1:0] pattern_mask(input logic [ADDR_W-1:0] pattern);
      logic [ADDR_W-1:0] mask;
      mask = '0;
      for (int k = 0; k < OCTETS; k++) begin
         if (pattern[8*k +: 8] != 8'd0) begin
            mask[8*k +: 8] = 8'hff;
         end
      end
      return mask;
   endfunction

endpackage

### hw/rtl/masked_address_filter_table_unit.sv
// IPv4 masked access control list.
// Input channel req_: req_valid / req_stall with a req_word_type word (kind, source
// address, filter pattern). A word is taken only while the sequencer is idle; the
// unit holds req_stall high for the whole time it works on one word.
// Result channel rsp_: rsp_valid / rsp_stall with a rsp_word_type word. Exactly one
// result word per input word. The result sits in an output register, so the next
// input word is taken while a result still waits; a stalled result holds steady,
// and a finished item waits in its result state until the output register frees up.
// Configuration: csr_valid / csr_ready with one bit, reject_on_match; always ready.
// Walk: each check, add or remove walks the stored entries through one read port and
// one shared comparator at one entry per cycle, up to the first match or the end of
// the list. A remove that hits then moves the later entries down one slot, one per
// cycle. The unused kind goes straight to its result state without a walk. The next
// word can be taken in the cycle after the result is loaded.
// Only the compare word of an entry is stored; its mask follows from its zero octets.
// Reset (synchronous, active high) empties the list and sets reject_on_match to 1;
// the entry memory itself is not cleared, since only entries below the count are read.
module masked_address_filter_table_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  maft_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output maft_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESULT
   } state_type;

   state_type                          state_ff, state_in;
   logic [1:0]                         kind_ff, kind_in;
   logic [maft_pkg::ADDR_W-1:0]        addr_ff, addr_in;
   logic [maft_pkg::ADDR_W-1:0]        pat_ff, pat_in;
   logic [maft_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [maft_pkg::CNT_W-1:0]         issue_idx_ff, issue_idx_in;
   logic [maft_pkg::CNT_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                               pend_ff, pend_in;
   logic                               mode_ff, mode_in;
   logic                               res_reject_ff, res_reject_in;
   logic [1:0]                         res_status_ff, res_status_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   maft_pkg::rsp_word_type             rsp_data_ff, rsp_data_in;

   // Entry memory: one read and one write port.
   logic [maft_pkg::ADDR_W-1:0]        entry_mem [maft_pkg::MAX_ENTRIES];
   logic [maft_pkg::ADDR_W-1:0]        rd_data_ff;
   logic                               rd_en;
   logic                               wr_en;
   logic [maft_pkg::IDX_W-1:0]         wr_addr;
   logic [maft_pkg::ADDR_W-1:0]        wr_data;

   logic                               match;
   logic                               hit;
   logic                               scan_end;
   logic [maft_pkg::CNT_W-1:0]         shift_dst;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Shared comparator on the entry that was read last cycle.
   always_comb begin
      case (kind_ff)
         maft_pkg::KIND_CHECK:
            match = ((addr_ff & maft_pkg::pattern_mask(rd_data_ff)) == rd_data_ff);
         maft_pkg::KIND_ADD:
            match = (rd_data_ff == '1);
         default:
            match = (rd_data_ff == pat_ff);
      endcase
   end

   assign hit       = pend_ff && match;
   assign scan_end  = !pend_ff && (issue_idx_ff == count_ff);
   assign rd_en     = (state_ff == ST_SCAN || state_ff == ST_SHIFT) && (issue_idx_ff < count_ff);
   assign shift_dst = cmp_idx_ff - maft_pkg::CNT_W'(1);

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      pat_in        = pat_ff;
      count_in      = count_ff;
      issue_idx_in  = issue_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      pend_in       = 1'b0;
      mode_in       = mode_ff;
      res_reject_in = res_reject_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = cmp_idx_ff[maft_pkg::IDX_W-1:0];
      wr_data       = pat_ff;

      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end

      // The output register empties when the receiver takes its word.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Read issue for scan and shift walks.
      if (rd_en) begin
         issue_idx_in = issue_idx_ff + maft_pkg::CNT_W'(1);
         pend_in      = 1'b1;
         cmp_idx_in   = issue_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in       = req_data.kind;
               addr_in       = req_data.source_address;
               pat_in        = req_data.filter_pattern;
               issue_idx_in  = '0;
               res_reject_in = 1'b0;
               res_status_in = maft_pkg::STAT_DONE;
               if (req_data.kind == maft_pkg::KIND_CHECK || req_data.kind == maft_pkg::KIND_ADD ||
                   req_data.kind == maft_pkg::KIND_REMOVE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end

         ST_SCAN: begin
            if (hit) begin
               case (kind_ff)
                  maft_pkg::KIND_CHECK: begin
                     res_reject_in = mode_ff;
                     state_in      = ST_RESULT;
                  end
                  maft_pkg::KIND_ADD: begin
                     // Reuse the first free slot.
                     wr_en    = 1'b1;
                     state_in = ST_RESULT;
                  end
                  default: begin
                     // Move the later entries down one slot.
                     issue_idx_in = cmp_idx_ff + maft_pkg::CNT_W'(1);
                     pend_in      = 1'b0;
                     state_in     = ST_SHIFT;
                  end
               endcase
            end else if (scan_end) begin
               case (kind_ff)
                  maft_pkg::KIND_CHECK: begin
                     res_reject_in = !mode_ff;
                  end
                  maft_pkg::KIND_ADD: begin
                     if (count_ff == maft_pkg::CNT_W'(maft_pkg::MAX_ENTRIES)) begin
                        res_status_in = maft_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[maft_pkg::IDX_W-1:0];
                        count_in = count_ff + maft_pkg::CNT_W'(1);
                     end
                  end
                  default: begin
                     res_status_in = maft_pkg::STAT_MISS;
                  end
               endcase
               state_in = ST_RESULT;
            end
         end

         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[maft_pkg::IDX_W-1:0];
               wr_data = rd_data_ff;
            end else if (scan_end) begin
               count_in = count_ff - maft_pkg::CNT_W'(1);
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.reject      = res_reject_ff;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.entry_total = count_ff;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         mode_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      pat_ff        <= pat_in;
      issue_idx_ff  <= issue_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_reject_ff <= res_reject_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Entry memory with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[issue_idx_ff[maft_pkg::IDX_W-1:0]];
      end
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // The entry count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= maft_pkg::CNT_W'(maft_pkg::MAX_ENTRIES))
      else $error("entry count above table size");

   // A new result word only comes out of the result state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT)
      else $error("result word without a finished item");

   // A shift write lands inside the list and never below slot zero.
   a_shift_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && pend_ff) |-> (cmp_idx_ff != '0 && cmp_idx_ff < count_ff))
      else $error("shift write outside the list");

   // The count changes only while an item is in work.
   a_count_stable_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESULT) |=> $stable(count_ff))
      else $error("entry count changed outside an item");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

// Shadow copy of the filter list. It predicts the result word of every accepted
// request word and checks the result words in order against those predictions.
class acl_shadow;
   logic [31:0]            mask_word    [maft_pkg::MAX_ENTRIES];
   logic [31:0]            compare_word [maft_pkg::MAX_ENTRIES];
   int                     used;
   bit                     reject_mode;
   maft_pkg::rsp_word_type verdicts_due [$];
   int unsigned            failures;
   int unsigned            checked;
   int unsigned            kind_tally [4];
   int unsigned            check_hits;
   int unsigned            remove_misses;

   function new();
      used          = 0;
      reject_mode   = 1'b1;
      failures      = 0;
      checked       = 0;
      check_hits    = 0;
      remove_misses = 0;
      foreach (kind_tally[k]) kind_tally[k] = 0;
   endfunction

   // A zero octet is a wildcard; every other octet must match in full.
   function logic [31:0] wildcard_mask(logic [31:0] pattern);
      logic [31:0] m;
      m = '0;
      for (int k = 0; k < 4; k++) begin
         if (pattern[8*k +: 8] != 8'h00) begin
            m[8*k +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   // Apply one accepted request word and queue the result word it must produce.
   function void take_request(maft_pkg::req_word_type w);
      maft_pkg::rsp_word_type v;
      logic [31:0]            m;
      bit                     found;
      int                     i;
      v = '0;
      found = 1'b0;
      kind_tally[w.kind]++;
      case (w.kind)
         maft_pkg::KIND_CHECK: begin
            for (i = 0; i < used; i++) begin
               if ((w.source_address & mask_word[i]) == compare_word[i]) begin
                  found = 1'b1;
                  break;
               end
            end
            if (found) check_hits++;
            v.reject = found ? reject_mode : !reject_mode;
         end
         maft_pkg::KIND_ADD: begin
            for (i = 0; i < used; i++) begin
               if (compare_word[i] == '1) break;
            end
            if (i == used) begin
               if (used >= maft_pkg::MAX_ENTRIES) begin
                  v.status = maft_pkg::STAT_FULL;
               end else begin
                  used++;
               end
            end
            if (v.status == maft_pkg::STAT_DONE) begin
               mask_word[i]    = wildcard_mask(w.filter_pattern);
               compare_word[i] = w.filter_pattern;
            end
         end
         maft_pkg::KIND_REMOVE: begin
            m = wildcard_mask(w.filter_pattern);
            v.status = maft_pkg::STAT_MISS;
            for (i = 0; i < used; i++) begin
               if (mask_word[i] == m && compare_word[i] == w.filter_pattern) begin
                  for (int j = i + 1; j < used; j++) begin
                     mask_word[j-1]    = mask_word[j];
                     compare_word[j-1] = compare_word[j];
                  end
                  used--;
                  v.status = maft_pkg::STAT_DONE;
                  break;
               end
            end
            if (v.status == maft_pkg::STAT_MISS) remove_misses++;
         end
         default: begin
            // The unused kind leaves the list alone and reports reject 0, status done and the entry count.
         end
      endcase
      v.entry_total = maft_pkg::CNT_W'(used);
      verdicts_due.push_back(v);
   endfunction

   // Compare one accepted result word with the oldest prediction.
   function void compare_result(maft_pkg::rsp_word_type got);
      maft_pkg::rsp_word_type want;
      if (verdicts_due.size() == 0) begin
         $error("result word with nothing pending: reject %0d status %0d entry_total %0d",
                got.reject, got.status, got.entry_total);
         failures++;
         return;
      end
      want = verdicts_due.pop_front();
      checked++;
      if (got.reject !== want.reject) begin
         $error("reject: expected %0d, actual %0d", want.reject, got.reject);
         failures++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         failures++;
      end
      if (got.entry_total !== want.entry_total) begin
         $error("entry_total: expected %0d, actual %0d", want.entry_total, got.entry_total);
         failures++;
      end
   endfunction
endclass

module testbench;

   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
   localparam int          CYCLE_LIMIT  = 8_000_000;
   localparam int          DRAIN_CYCLES = 2 * maft_pkg::MAX_ENTRIES + 16;
   localparam int          RANDOM_HALF  = 270;
   localparam int          SMALL_LIST   = 24;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          HOLD_AFTER   = 60;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   maft_pkg::req_word_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   maft_pkg::rsp_word_type rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic                   csr_data;

   bit           no_gaps = 1'b0;
   int unsigned  results_seen = 0;
   int unsigned  cycle_count = 0;

   acl_shadow acl_copy = new();

   masked_address_filter_table_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result words are taken at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         acl_copy.compare_result(rsp_data);
         results_seen <= results_seen + 1;
      end
   end

   // Result side: random stalls, one long hold-off to back the unit up.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_gaps && ($urandom_range(99) < 26);
         end
      end
   end

   // Offer one request word, with an optional idle gap in front of it.
   task automatic send_word(input maft_pkg::req_word_type w);
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      acl_copy.take_request(w);
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [31:0] address,
                              input logic [31:0] pattern);
      maft_pkg::req_word_type w;
      w.kind           = kind;
      w.source_address = address;
      w.filter_pattern = pattern;
      send_word(w);
   endtask

   // The mode register is written only once every pending result has come back.
   task automatic set_mode(input bit mode);
      @(negedge clock);
      req_valid <= 1'b0;
      while (acl_copy.verdicts_due.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      acl_copy.reject_mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Octets are wildcards, full ones or random; now and then a free-slot marker.
   function automatic logic [31:0] random_pattern();
      logic [31:0] p;
      int          r;
      if ($urandom_range(49) == 0) return ALL_ONES;
      p = '0;
      for (int k = 0; k < 4; k++) begin
         r = $urandom_range(9);
         if (r < 3) begin
            p[8*k +: 8] = 8'h00;
         end else if (r < 5) begin
            p[8*k +: 8] = 8'hff;
         end else begin
            p[8*k +: 8] = 8'($urandom_range(254, 1));
         end
      end
      return p;
   endfunction

   // Half the addresses are built to hit a stored entry.
   function automatic logic [31:0] random_address();
      int idx;
      if (acl_copy.used == 0 || $urandom_range(1) == 0) return $urandom;
      idx = $urandom_range(acl_copy.used - 1);
      return acl_copy.compare_word[idx] | ($urandom & ~acl_copy.mask_word[idx]);
   endfunction

   // One random word; the list is kept short so that scans stay quick.
   task automatic send_random_item(output bit counted);
      maft_pkg::req_word_type w;
      int                     r;
      w.kind           = maft_pkg::KIND_CHECK;
      w.source_address = $urandom;
      w.filter_pattern = $urandom;
      counted          = 1'b1;
      r = $urandom_range(99);
      if (r < 45) begin
         w.source_address = random_address();
      end else if (r < 72 && acl_copy.used < SMALL_LIST) begin
         w.kind           = maft_pkg::KIND_ADD;
         w.filter_pattern = random_pattern();
      end else if (r < 96) begin
         w.kind = maft_pkg::KIND_REMOVE;
         if (acl_copy.used > 0 && $urandom_range(3) != 0) begin
            w.filter_pattern = acl_copy.compare_word[$urandom_range(acl_copy.used - 1)];
         end else begin
            w.filter_pattern = random_pattern();
         end
      end else begin
         w.kind  = KIND_UNUSED;
         counted = 1'b0;
      end
      send_word(w);
   endtask

   // Stimulus.
   initial begin
      bit           counted;
      int           done_items;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = 1'b0;
      reset     = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset mode (refuse on match).
      // Addresses hold the first dotted octet in bits 7:0.
      send_fields(maft_pkg::KIND_CHECK, 32'h0000_0000, 32'h0000_0000);
      send_fields(maft_pkg::KIND_CHECK, ALL_ONES, ALL_ONES);
      send_fields(maft_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0000_000a);
      send_fields(KIND_UNUSED, ALL_ONES, ALL_ONES);
      send_fields(maft_pkg::KIND_ADD, 32'h0000_0000, 32'h0102_030a);
      send_fields(maft_pkg::KIND_ADD, 32'h0000_0000, 32'h0000_a8c0);
      send_fields(maft_pkg::KIND_ADD, 32'h0000_0000, ALL_ONES);
      send_fields(maft_pkg::KIND_CHECK, 32'h0102_030a, 32'h0000_0000);
      send_fields(maft_pkg::KIND_CHECK, 32'h7777_a8c0, 32'h0000_0000);
      send_fields(maft_pkg::KIND_CHECK, 32'h1234_5678, 32'h0000_0000);
      send_fields(maft_pkg::KIND_CHECK, ALL_ONES, 32'h0000_0000);
      // The all-ones entry is a free slot and gets overwritten.
      send_fields(maft_pkg::KIND_ADD, 32'h0000_0000, 32'h0000_00ac);
      send_fields(maft_pkg::KIND_CHECK, 32'hdead_beac, 32'h0000_0000);
      send_fields(maft_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0000_a8c0);
      send_fields(maft_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0000_a8c0);
      send_fields(maft_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0102_030b);
      // An all-wildcard entry matches every address.
      send_fields(maft_pkg::KIND_ADD, 32'h0000_0000, 32'h0000_0000);
      send_fields(maft_pkg::KIND_CHECK, 32'h5555_5555, 32'h0000_0000);
      send_fields(maft_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0102_030a);
      send_fields(maft_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0000_00ac);
      send_fields(maft_pkg::KIND_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_fields(maft_pkg::KIND_CHECK, 32'h0102_030a, 32'h0000_0000);
      send_fields(KIND_UNUSED, 32'h0000_0000, 32'h0000_0000);

      // Random words in admit-only-matching mode, with one stretch without gaps.
      set_mode(1'b0);
      done_items = 0;
      while (done_items < RANDOM_HALF) begin
         no_gaps = (done_items >= 100 && done_items < 180);
         send_random_item(counted);
         if (counted) done_items++;
      end
      no_gaps = 1'b0;

      // Random words in refuse-on-match mode.
      set_mode(1'b1);
      done_items = 0;
      while (done_items < RANDOM_HALF) begin
         send_random_item(counted);
         if (counted) done_items++;
      end

      // A few closing words in admit-only-matching mode.
      set_mode(1'b0);
      send_fields(maft_pkg::KIND_ADD, $urandom, 32'h0a0b_0c0d);
      send_fields(maft_pkg::KIND_CHECK, acl_copy.compare_word[0], $urandom);
      send_fields(maft_pkg::KIND_CHECK, 32'h0303_0303, $urandom);
      send_fields(maft_pkg::KIND_REMOVE, $urandom, acl_copy.compare_word[0]);
      send_fields(maft_pkg::KIND_CHECK, random_address(), $urandom);

      // Drain.
      @(negedge clock);
      req_valid <= 1'b0;
      while (acl_copy.verdicts_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d checks (%0d hits), %0d adds, %0d removes (%0d misses), %0d unused.",
               acl_copy.kind_tally[maft_pkg::KIND_CHECK], acl_copy.check_hits,
               acl_copy.kind_tally[maft_pkg::KIND_ADD],
               acl_copy.kind_tally[maft_pkg::KIND_REMOVE], acl_copy.remove_misses,
               acl_copy.kind_tally[KIND_UNUSED]);
      $display("Both reject modes and one long result hold-off; %0d results compared.",
               acl_copy.checked);
      if (acl_copy.failures == 0 && acl_copy.verdicts_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/maft_pkg.sv
hw/rtl/masked_address_filter_table_unit.sv
tb/testbench.sv
